// File: src/fir_convolution_filter_defines.svh
// ----------------------------------------------------------------------------
// FIR convolution filter assertion macros
// Concurrent assertion helpers used by the filter's top level.
// ----------------------------------------------------------------------------
`ifndef FIR_CONVOLUTION_FILTER_DEFINES_SVH
`define FIR_CONVOLUTION_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

`define FCF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define FCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define FCF_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)

`define FCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/fcf_pkg.sv
// ----------------------------------------------------------------------------
// FIR convolution filter package
// Request and response types, control groups and constants of the filter.
// ----------------------------------------------------------------------------
package fcf_pkg;

  localparam int FilterOrderDefault = 64;
  localparam int AdcMid             = 2047;
  localparam int GainDivisor        = 1056;
  localparam int DacMax             = 4095;
  localparam int SampleW            = 12;
  localparam int SmpW               = 13;
  localparam int CoefW              = 16;
  localparam int CoefIdxW           = 8;
  localparam int DacW               = 12;
  localparam int ProdW              = SmpW + CoefW;

  typedef enum logic {
    FCF_MODE_SAMPLE = 1'b0,
    FCF_MODE_COEF   = 1'b1
  } fcf_mode_e;

  typedef struct packed {
    fcf_mode_e                   mode;
    logic [SampleW-1:0]          sample;
    logic [CoefIdxW-1:0]         coef_index;
    logic signed [CoefW-1:0]     coef_value;
  } fcf_req_t;

  typedef struct packed {
    logic [DacW-1:0] dac_value;
    logic            clipped;
  } fcf_rsp_t;

  typedef struct packed {
    logic coef_we;
    logic smp_we;
    logic rd_en;
  } fcf_tap_ctrl_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } fcf_mac_ctrl_t;

endpackage

// File: src/fcf_taps.sv
// ----------------------------------------------------------------------------
// FIR tap storage
// Coefficient memory and circular delay-line memory with registered reads.
// ----------------------------------------------------------------------------
module fcf_taps #(
  parameter int FILTER_ORDER = fcf_pkg::FilterOrderDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fcf_pkg::fcf_tap_ctrl_t             ctrl_i,
  input  logic [$clog2(FILTER_ORDER+1)-1:0]  coef_idx_i,
  input  logic signed [fcf_pkg::CoefW-1:0]   coef_val_i,
  input  logic signed [fcf_pkg::SmpW-1:0]    smp_i,
  input  logic [$clog2(FILTER_ORDER+1)-1:0]  k_i,
  output logic                               rd_vld_o,
  output logic signed [fcf_pkg::CoefW-1:0]   coef_o,
  output logic signed [fcf_pkg::SmpW-1:0]    smp_o
);
  import fcf_pkg::*;

  localparam int TapCount = FILTER_ORDER + 1;
  localparam int IdxW     = $clog2(TapCount);
  localparam int FillW    = $clog2(TapCount + 1);

  logic signed [CoefW-1:0] coef_mem [TapCount];
  logic signed [SmpW-1:0]  dl_mem   [TapCount];

  logic [TapCount-1:0]     coef_vld_q;
  logic [IdxW-1:0]         wp_q, wp_nxt;
  logic [IdxW-1:0]         rd_ptr_q;
  logic [FillW-1:0]        fill_q;
  logic                    rd_vld_q;
  logic                    coef_ok_q, smp_ok_q;
  logic signed [CoefW-1:0] coef_rd_q;
  logic signed [SmpW-1:0]  smp_rd_q;

  assign wp_nxt = (wp_q == IdxW'(TapCount - 1)) ? '0 : wp_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.coef_we) begin
      coef_mem[coef_idx_i] <= coef_val_i;
    end
    if (ctrl_i.smp_we) begin
      dl_mem[wp_nxt] <= smp_i;
    end
    if (ctrl_i.rd_en) begin
      coef_rd_q <= coef_mem[k_i];
      smp_rd_q  <= dl_mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      wp_q       <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
      rd_vld_q   <= 1'b0;
      coef_ok_q  <= 1'b0;
      smp_ok_q   <= 1'b0;
    end else begin
      rd_vld_q <= ctrl_i.rd_en;
      if (ctrl_i.coef_we) begin
        coef_vld_q[coef_idx_i] <= 1'b1;
      end
      if (ctrl_i.smp_we) begin
        wp_q     <= wp_nxt;
        rd_ptr_q <= wp_nxt;
        if (fill_q != FillW'(TapCount)) begin
          fill_q <= fill_q + 1'b1;
        end
      end else if (ctrl_i.rd_en) begin
        rd_ptr_q <= (rd_ptr_q == '0) ? IdxW'(TapCount - 1) : rd_ptr_q - 1'b1;
      end
      if (ctrl_i.rd_en) begin
        coef_ok_q <= coef_vld_q[k_i];
        smp_ok_q  <= (FillW'(k_i) < fill_q);
      end
    end
  end

  assign rd_vld_o = rd_vld_q;
  assign coef_o   = coef_ok_q ? coef_rd_q : '0;
  assign smp_o    = smp_ok_q ? smp_rd_q : '0;

endmodule

// File: src/fcf_mac.sv
// ----------------------------------------------------------------------------
// FIR multiply-accumulate unit
// One registered signed multiplier feeding a wide accumulator.
// ----------------------------------------------------------------------------
module fcf_mac #(
  parameter int FILTER_ORDER = fcf_pkg::FilterOrderDefault
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  fcf_pkg::fcf_mac_ctrl_t                                   ctrl_i,
  input  logic signed [fcf_pkg::CoefW-1:0]                         coef_i,
  input  logic signed [fcf_pkg::SmpW-1:0]                          smp_i,
  output logic                                                     prod_vld_o,
  output logic signed [fcf_pkg::ProdW+$clog2(FILTER_ORDER+1)-1:0]  acc_o
);
  import fcf_pkg::*;

  localparam int AccW = ProdW + $clog2(FILTER_ORDER + 1);

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_vld_q;
  logic signed [AccW-1:0]  acc_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= ProdW'(coef_i) * ProdW'(smp_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      acc_q      <= '0;
    end else begin
      prod_vld_q <= ctrl_i.vld;
      if (ctrl_i.clear) begin
        acc_q <= '0;
      end else if (prod_vld_q) begin
        acc_q <= acc_q + {{(AccW - ProdW){prod_q[ProdW-1]}}, prod_q};
      end
    end
  end

  assign prod_vld_o = prod_vld_q;
  assign acc_o      = acc_q;

endmodule

// File: src/fcf_div.sv
// ----------------------------------------------------------------------------
// FIR output scaler
// Reciprocal-multiply division by the gain divisor, offset and saturation.
// ----------------------------------------------------------------------------
module fcf_div #(
  parameter int FILTER_ORDER = fcf_pkg::FilterOrderDefault
) (
  input  logic                                                     clk_i,
  input  logic                                                     rst_ni,
  input  logic                                                     start_i,
  input  logic signed [fcf_pkg::ProdW+$clog2(FILTER_ORDER+1)-1:0]  acc_i,
  output logic                                                     done_o,
  output fcf_pkg::fcf_rsp_t                                        rsp_o
);
  import fcf_pkg::*;

  // The divisor is 32 * 33: the magnitude is shifted by five and then
  // multiplied by a scaled reciprocal of 33, which is exact for every
  // magnitude below the saturation limit.
  localparam int AccW       = ProdW + $clog2(FILTER_ORDER + 1);
  localparam int DivShift   = 5;
  localparam int OddDiv     = GainDivisor >> DivShift;
  localparam int MagW       = 17;
  localparam int RecipW     = 18;
  localparam int RecipShift = 23;
  localparam int ProdRW     = MagW + RecipW;
  localparam int Recip      = ((1 << RecipShift) + OddDiv - 1) / OddDiv;
  localparam int QuoLimit   = (DacMax - AdcMid + 1) * GainDivisor;

  localparam logic [RecipW-1:0] RecipVal = RecipW'(Recip);

  logic              s1_q, fin_q, done_q;
  logic [AccW-1:0]   mag_q;
  logic              neg_q, over_q;
  logic [ProdRW-1:0] prod_q;
  logic [DacW-1:0]   quo;
  fcf_rsp_t          rsp_q, rsp_d;

  assign quo = over_q ? '1 : prod_q[RecipShift +: DacW];

  always_comb begin
    rsp_d = '0;
    if (neg_q) begin
      if (quo > DacW'(AdcMid)) begin
        rsp_d.clipped = 1'b1;
      end else begin
        rsp_d.dac_value = DacW'(AdcMid) - quo;
      end
    end else begin
      if (quo > DacW'(DacMax - AdcMid)) begin
        rsp_d.dac_value = DacW'(DacMax);
        rsp_d.clipped   = 1'b1;
      end else begin
        rsp_d.dac_value = DacW'(AdcMid) + quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= acc_i[AccW-1] ? $unsigned(-acc_i) : $unsigned(acc_i);
      neg_q <= acc_i[AccW-1];
    end
    if (s1_q) begin
      prod_q <= mag_q[DivShift +: MagW] * RecipVal;
      over_q <= (mag_q >= AccW'(QuoLimit));
    end
    if (fin_q) begin
      rsp_q <= rsp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      fin_q  <= s1_q;
      done_q <= fin_q;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: src/fir_convolution_filter.sv
// ----------------------------------------------------------------------------
// FIR convolution filter
// Direct-form FIR filter from a 12-bit converter input to a 12-bit output.
// ----------------------------------------------------------------------------
// A coefficient request (mode 1) stores one tap weight; writes beyond the
// filter order are dropped. A sample request is processed in steps: it is
// taken, each tap in turn passes through the single multiplier and
// accumulator, the read and multiply stages are emptied and the scaler is
// started, the scaler divides by 1056 with a reciprocal multiply, and the
// result passes to the output register. The input stalls while a sample is
// processed, and longer if the previous result is still held under an output
// stall; a finished result waits in the output register, so a new request
// can be taken before it is collected.
`include "fir_convolution_filter_defines.svh"

module fir_convolution_filter #(
  parameter int FILTER_ORDER = fcf_pkg::FilterOrderDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  fcf_pkg::fcf_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output fcf_pkg::fcf_rsp_t out_rsp_o
);
  import fcf_pkg::*;

  localparam int TapCount = FILTER_ORDER + 1;
  localparam int IdxW     = $clog2(TapCount);
  localparam int AccW     = ProdW + IdxW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DIV,
    ST_HOLD
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] k_q, k_d;
  logic            out_valid_q, out_valid_d;
  fcf_rsp_t        out_rsp_q, out_rsp_d;

  logic                    in_acc;
  logic                    div_start, div_done, out_load;
  fcf_tap_ctrl_t           tap_ctrl;
  fcf_mac_ctrl_t           mac_ctrl;
  logic                    tap_rd_vld, prod_vld;
  logic signed [CoefW-1:0] tap_coef;
  logic signed [SmpW-1:0]  tap_smp, centered;
  logic signed [AccW-1:0]  acc;
  fcf_rsp_t                div_rsp;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);
  assign centered   = SmpW'({1'b0, in_req_i.sample}) - SmpW'(AdcMid);

  always_comb begin
    tap_ctrl.coef_we = in_acc && (in_req_i.mode == FCF_MODE_COEF) &&
                       (in_req_i.coef_index <= CoefIdxW'(FILTER_ORDER));
    tap_ctrl.smp_we  = in_acc && (in_req_i.mode == FCF_MODE_SAMPLE);
    tap_ctrl.rd_en   = (state_q == ST_RUN);
    mac_ctrl.clear   = tap_ctrl.smp_we;
    mac_ctrl.vld     = tap_rd_vld;
  end

  assign div_start = (state_q == ST_DRAIN) && !tap_rd_vld && !prod_vld;
  assign out_load  = (state_q == ST_HOLD) && (!out_valid_q || !out_stall_i);

  fcf_taps #(
    .FILTER_ORDER(FILTER_ORDER)
  ) u_taps (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (tap_ctrl),
    .coef_idx_i(in_req_i.coef_index[IdxW-1:0]),
    .coef_val_i(in_req_i.coef_value),
    .smp_i     (centered),
    .k_i       (k_q),
    .rd_vld_o  (tap_rd_vld),
    .coef_o    (tap_coef),
    .smp_o     (tap_smp)
  );

  fcf_mac #(
    .FILTER_ORDER(FILTER_ORDER)
  ) u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mac_ctrl),
    .coef_i    (tap_coef),
    .smp_i     (tap_smp),
    .prod_vld_o(prod_vld),
    .acc_o     (acc)
  );

  fcf_div #(
    .FILTER_ORDER(FILTER_ORDER)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .acc_i  (acc),
    .done_o (div_done),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    case (state_q)
      ST_IDLE: begin
        if (tap_ctrl.smp_we) begin
          state_d = ST_RUN;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        if (k_q == IdxW'(TapCount - 1)) begin
          state_d = ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          out_rsp_d   = div_rsp;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_rsp_q   <= '0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      out_rsp_q   <= out_rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `FCF_ASSERT_NEXT(a_sample_busy, clk_i, rst_ni,
    in_valid_i && !in_stall_o && (in_req_i.mode == FCF_MODE_SAMPLE), in_stall_o)
  `FCF_ASSERT_IMPLIES(a_clip_at_rail, clk_i, rst_ni, out_valid_o && out_rsp_o.clipped,
    (out_rsp_o.dac_value == '0) || (out_rsp_o.dac_value == DacW'(DacMax)))
  `FCF_ASSERT_IMPLIES(a_idle_pipe_empty, clk_i, rst_ni, state_q == ST_IDLE,
    !tap_rd_vld && !prod_vld)

endmodule
